// ===== src/sce_pkg.sv =====
// Shared types, register indexes and the divide-by-count table of the contour erosion block.
package sce_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ROW_W = 12;
	localparam int FW_W = 11;
	localparam int SUM_W = 11;
	localparam int CNT_W = 4;
	localparam int RECIP_W = 16;
	localparam int RECIP_SH = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ANY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

	typedef logic [2*PIX_W-1:0] pix_t;  // label high byte, gray low byte

	typedef struct packed {
		logic match_any;
		logic [PIX_W-1:0] level;
		logic signed [15:0] threshold;
	} sce_cfg_t;

	typedef struct packed {
		logic erased;
		logic [PIX_W-1:0] label;
	} sce_res_t;

	// ceil(2^16 / n): exact quotient for sums up to 8 * 255
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		begin
			case (n)
				4'd2: r = 16'd32768;
				4'd3: r = 16'd21846;
				4'd4: r = 16'd16384;
				4'd5: r = 16'd13108;
				4'd6: r = 16'd10923;
				4'd7: r = 16'd9363;
				4'd8: r = 16'd8192;
				default: r = 16'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== src/sce_eval.sv =====
// Four-stage erase decision for the center of one 3x3 window.
module sce_eval
	import sce_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [8:0][2*PIX_W-1:0] win,
	input  sce_cfg_t cfg,
	output logic done,
	output sce_res_t res
);

	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: membership, zero-label neighbor count and gray sum
	logic [SUM_W-1:0] sum_c;
	logic [CNT_W-1:0] cnt_c;
	logic member_c;
	logic [SUM_W-1:0] sum_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic member_s1;
	logic [PIX_W-1:0] cg_s1, cl_s1;

	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4 && win[i][2*PIX_W-1:PIX_W] == '0) begin
				sum_c = sum_c + SUM_W'(win[i][PIX_W-1:0]);
				cnt_c = cnt_c + CNT_W'(1);
			end
		end
		if (cfg.match_any)
			member_c = win[4][2*PIX_W-1:PIX_W] != '0;
		else
			member_c = win[4][2*PIX_W-1:PIX_W] == cfg.level;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_s1 <= sum_c;
			cnt_s1 <= cnt_c;
			member_s1 <= member_c;
			cg_s1 <= win[4][PIX_W-1:0];
			cl_s1 <= win[4][2*PIX_W-1:PIX_W];
		end
	end

	// stage 2: mean gray through reciprocal multiply
	logic [SUM_W+RECIP_W-1:0] quot_c;
	logic [PIX_W-1:0] a_s2, cg_s2, cl_s2;
	logic ok_s2;

	assign quot_c = SUM_W'(sum_s1) * recip(cnt_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			a_s2 <= quot_c[RECIP_SH +: PIX_W];
			cg_s2 <= cg_s1;
			cl_s2 <= cl_s1;
			ok_s2 <= member_s1 && (cnt_s1 >= CNT_W'(2));
		end
	end

	// stage 3: sum, scaled contrast and threshold product
	logic [PIX_W:0] s_c;
	logic [PIX_W-1:0] ad_c;
	logic signed [PIX_W+1:0] s_sgn;
	logic signed [PIX_W+17:0] prod_c;
	logic [PIX_W:0] s_s3;
	logic [PIX_W+8:0] d_s3;
	logic signed [PIX_W+17:0] prod_s3;
	logic ok_s3;
	logic [PIX_W-1:0] cl_s3;

	always_comb begin
		s_c = {1'b0, a_s2} + {1'b0, cg_s2};
		ad_c = (a_s2 >= cg_s2) ? (a_s2 - cg_s2) : (cg_s2 - a_s2);
		s_sgn = signed'({1'b0, s_c});
		prod_c = (PIX_W+18)'(s_sgn) * (PIX_W+18)'(cfg.threshold);
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			s_s3 <= s_c;
			d_s3 <= {ad_c, 9'd0};
			prod_s3 <= prod_c;
			ok_s3 <= ok_s2;
			cl_s3 <= cl_s2;
		end
	end

	// stage 4: compares
	logic gt_c, lt_c, er_c;

	always_comb begin
		gt_c = signed'({7'd0, s_s3}) > 17'(cfg.threshold);
		lt_c = signed'({1'b0, d_s3}) < prod_s3;
		er_c = ok_s3 && gt_c && lt_c;
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			res.erased <= er_c;
			res.label <= er_c ? '0 : cl_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign done = v_s4;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !start && !v_s2 && !v_s3 && !v_s4)
		else $error("eval restarted while busy");

endmodule

// ===== src/selective_contour_erosion_3x3_top.sv =====
// Top level: configuration, line store memory, 3x3 window, control and output register.
//
// One erosion pass over a raster stream of (label, gray) pixels. Each accepted word reads its
// column from a single line store memory (registered read), then writes back the shifted column
// and updates the 3x3 window. A word in the first two rows or columns gives no result and goes
// back to idle after READ. Any other word runs through the 4-stage decision unit, and the next
// word is accepted only once its result is in the output register; a held output word stalls
// that in EMIT. The line store needs no clearing: every entry that feeds a decision is written
// earlier in the same frame. Frame width is clamped to 3..MAX_WIDTH and height to at least 3;
// pass_changed rides on the tlast word.
module selective_contour_erosion_3x3_top
	import sce_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata,  // [7:0] label_pixel, [15:8] gray_pixel
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,  // [7:0] label_result, [8] erased, [9] pass_changed, rest zero
	output logic m_tlast
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WEW = CW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	// configuration
	logic match_any_q;
	logic [PIX_W-1:0] level_q;
	logic signed [15:0] threshold_q;
	logic [FW_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_any_q <= 1'b1;
			level_q <= 8'd255;
			threshold_q <= '0;
			width_q <= 11'd1024;
			height_q <= 12'd4095;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MATCH_ANY: match_any_q <= cfg_wdata[0];
				CFG_LEVEL: level_q <= cfg_wdata[PIX_W-1:0];
				CFG_THRESHOLD: threshold_q <= signed'(cfg_wdata);
				CFG_WIDTH: width_q <= cfg_wdata[FW_W-1:0];
				CFG_HEIGHT: height_q <= cfg_wdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	sce_cfg_t eval_cfg;
	assign eval_cfg = {match_any_q, level_q, threshold_q};

	// effective geometry
	logic [WEW-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [CW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic last_col, last_row;

	always_comb begin
		if (width_q < FW_W'(3))
			w_eff = WEW'(3);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = WEW'(MAX_WIDTH);
		else
			w_eff = WEW'(width_q);
		h_eff = (height_q < ROW_W'(3)) ? ROW_W'(3) : height_q;
		last_col = {1'b0, col_q} >= (w_eff - WEW'(1));
		last_row = row_q >= (h_eff - ROW_W'(1));
	end

	logic [1:0] state_q;
	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// line store: [31:16] newer line, [15:0] older line, each label:gray
	logic [4*PIX_W-1:0] mem [MAX_WIDTH];
	logic [4*PIX_W-1:0] rd_q;
	logic [CW-1:0] addr_q;
	pix_t pix_q;
	logic need_q, last_q;

	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= mem[col_q];
		if (state_q == ST_READ)
			mem[addr_q] <= {pix_q, rd_q[4*PIX_W-1:2*PIX_W]};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= col_q;
			pix_q[PIX_W-1:0] <= s_tdata[15:8];
			pix_q[2*PIX_W-1:PIX_W] <= (row_q == '0 || last_row || col_q == '0 || last_col)
				? '0 : s_tdata[7:0];
			need_q <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
			last_q <= last_row && last_col;
		end
	end

	// window: index row*3+col, row 0 oldest line, col 2 newest column
	logic [8:0][2*PIX_W-1:0] win_q;
	logic start_q;
	logic done;
	sce_res_t res;
	logic out_free;
	logic any_erased_q;
	logic out_valid_q;
	sce_res_t out_res_q;
	logic out_last_q, out_pc_q;
	logic load_out;

	assign out_free = !out_valid_q || m_tready;
	assign load_out = (state_q == ST_EVAL && done && out_free) || (state_q == ST_EMIT && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
			start_q <= 1'b0;
			any_erased_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
						if (last_col) begin
							col_q <= '0;
							row_q <= last_row ? '0 : row_q + ROW_W'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				ST_READ: begin
					for (int k = 0; k < 3; k++) begin
						win_q[k*3] <= win_q[k*3+1];
						win_q[k*3+1] <= win_q[k*3+2];
					end
					win_q[2] <= rd_q[2*PIX_W-1:0];
					win_q[5] <= rd_q[4*PIX_W-1:2*PIX_W];
					win_q[8] <= pix_q;
					start_q <= need_q;
					state_q <= need_q ? ST_EVAL : ST_IDLE;
				end
				ST_EVAL: begin
					if (done)
						state_q <= out_free ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
				any_erased_q <= last_q ? 1'b0 : (any_erased_q | res.erased);
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_res_q <= res;
			out_last_q <= last_q;
			out_pc_q <= last_q && (any_erased_q || res.erased);
		end
	end

	sce_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_q),
		.win(win_q),
		.cfg(eval_cfg),
		.done(done),
		.res(res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_pc_q, out_res_q.erased, out_res_q.label};
	assign m_tlast = out_last_q;

	a_done_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_EVAL)
		else $error("decision finished outside evaluation");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_READ && !start_q)
		else $error("accepted word did not go to line read");

	a_pc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tlast)
		else $error("pass_changed outside last word");

	a_flag_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && last_q |=> !any_erased_q)
		else $error("erase flag not cleared at end of pass");

	a_wait_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> out_valid_q)
		else $error("result held with free output register");

endmodule

// ===== tb/tb_selective_contour_erosion_3x3_top.sv =====
// Self-checking testbench for the 3x3 selective contour erosion block with a built-in predictor.
module tb_selective_contour_erosion_3x3_top
	import sce_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 1024;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PIXELS = 300;

	typedef struct {
		logic [7:0] label;
		logic erased;
		logic last;
		logic changed;
	} erosion_word_t;

	typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_LONG_STALL} ready_mode_e;

	class erosion_scoreboard;
		logic match_any;
		logic [7:0] level;
		logic signed [15:0] thresh;
		logic [10:0] width;
		logic [11:0] height;
		logic [7:0] lab_line [2][MAX_W];
		logic [7:0] gray_line [2][MAX_W];
		logic [7:0] win_lab [3][3];
		logic [7:0] win_gray [3][3];
		int unsigned col;
		int unsigned row;
		logic any_erased;
		erosion_word_t expected_pixels[$];
		int fail_count;

		function new();
			match_any = 1'b1;
			level = 8'd255;
			thresh = '0;
			width = 11'd1024;
			height = 12'd4095;
			for (int i = 0; i < MAX_W; i++) begin
				lab_line[0][i] = '0;
				lab_line[1][i] = '0;
				gray_line[0][i] = '0;
				gray_line[1][i] = '0;
			end
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					win_lab[r][c] = '0;
					win_gray[r][c] = '0;
				end
			col = 0;
			row = 0;
			any_erased = 1'b0;
			fail_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_MATCH_ANY: match_any = value[0];
				CFG_LEVEL: level = value[7:0];
				CFG_THRESHOLD: thresh = value;
				CFG_WIDTH: width = value[10:0];
				CFG_HEIGHT: height = value[11:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_width();
			if (width < 3) return 3;
			if (width > MAX_W) return MAX_W;
			return width;
		endfunction

		function int unsigned eff_height();
			return (height < 3) ? 3 : height;
		endfunction

		// 1 when the window center is removed
		function bit erode_center();
			int sum, cnt, mean, total, diff, th, center;
			sum = 0;
			cnt = 0;
			center = win_gray[1][1];
			th = thresh;
			if (match_any ? (win_lab[1][1] == 8'd0) : (win_lab[1][1] != level))
				return 1'b0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					if (!(r == 1 && c == 1) && win_lab[r][c] == 8'd0) begin
						sum += int'(win_gray[r][c]);
						cnt++;
					end
			if (cnt < 2)
				return 1'b0;
			mean = sum / cnt;
			total = mean + center;
			if (total <= th)
				return 1'b0;
			diff = mean - center;
			if (diff < 0)
				diff = -diff;
			return (diff * 512 < th * total);
		endfunction

		function void take_pixel(logic [7:0] lab, logic [7:0] gray);
			int unsigned w, h, ci;
			bit last_col, last_row, erased;
			erosion_word_t word;
			w = eff_width();
			h = eff_height();
			ci = col % MAX_W;
			last_col = (col >= w - 1);
			last_row = (row >= h - 1);
			if (row == 0 || last_row || col == 0 || last_col)
				lab = 8'd0;
			for (int k = 0; k < 3; k++) begin
				win_lab[k][0] = win_lab[k][1];
				win_lab[k][1] = win_lab[k][2];
				win_gray[k][0] = win_gray[k][1];
				win_gray[k][1] = win_gray[k][2];
			end
			win_lab[0][2] = lab_line[0][ci];
			win_gray[0][2] = gray_line[0][ci];
			win_lab[1][2] = lab_line[1][ci];
			win_gray[1][2] = gray_line[1][ci];
			win_lab[2][2] = lab;
			win_gray[2][2] = gray;
			lab_line[0][ci] = lab_line[1][ci];
			gray_line[0][ci] = gray_line[1][ci];
			lab_line[1][ci] = lab;
			gray_line[1][ci] = gray;
			if (row >= 2 && col >= 2) begin
				erased = erode_center();
				if (erased)
					any_erased = 1'b1;
				word.label = erased ? 8'd0 : win_lab[1][1];
				word.erased = erased;
				word.last = last_row && last_col;
				word.changed = word.last && any_erased;
				expected_pixels.push_back(word);
			end
			if (last_col) begin
				col = 0;
				if (last_row) begin
					row = 0;
					any_erased = 1'b0;
				end else begin
					row = (row + 1) & 12'hFFF;
				end
			end else begin
				col = (col + 1) & 10'h3FF;
			end
		endfunction

		// pixels still needed to close the frame under the current geometry
		function int unsigned pixels_to_frame_end();
			int unsigned w, h, in_row;
			w = eff_width();
			h = eff_height();
			in_row = (col >= w - 1) ? 1 : w - col;
			return in_row + ((row >= h - 1) ? 0 : (h - 1 - row) * w);
		endfunction

		function void check_pixel(logic [15:0] data, logic last);
			erosion_word_t want;
			if (expected_pixels.size() == 0) begin
				$error("unexpected result word: tdata %h tlast %b", data, last);
				fail_count++;
				return;
			end
			want = expected_pixels.pop_front();
			if (data[7:0] !== want.label) begin
				$error("label_result: expected %0d, got %0d", want.label, data[7:0]);
				fail_count++;
			end
			if (data[8] !== want.erased) begin
				$error("erased: expected %0b, got %0b", want.erased, data[8]);
				fail_count++;
			end
			if (last !== want.last) begin
				$error("last_of_pass: expected %0b, got %0b", want.last, last);
				fail_count++;
			end
			if (data[9] !== want.changed) begin
				$error("pass_changed: expected %0b, got %0b", want.changed, data[9]);
				fail_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic m_tlast;

	erosion_scoreboard board;
	int idle_cycles = 0;
	int pixels_sent = 0;
	ready_mode_e ready_mode = READY_ALWAYS;
	int mode_left = 0;
	int stall_tick = 0;

	// stimulus shaping for the running phase
	logic cur_any;
	logic [7:0] cur_level;
	logic [7:0] fg_label;
	int gray_base;
	bit gaps_on;

	logic [7:0] dir_lab [25] = '{
		8'd255, 8'd7, 8'd1, 8'd128, 8'd255,
		8'd9, 8'd0, 8'd5, 8'd5, 8'd3,
		8'd0, 8'd5, 8'd255, 8'd5, 8'd0,
		8'd4, 8'd0, 8'd5, 8'd1, 8'd8,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
	logic [7:0] dir_gray [25] = '{
		8'd0, 8'd255, 8'd200, 8'd190, 8'd210,
		8'd180, 8'd220, 8'd200, 8'd205, 8'd0,
		8'd255, 8'd200, 8'd40, 8'd210, 8'd195,
		8'd200, 8'd190, 8'd205, 8'd255, 8'd128,
		8'd60, 8'd200, 8'd200, 8'd200, 8'd255};

	selective_contour_erosion_3x3_top #(.MAX_WIDTH(MAX_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 400);
		end
		mode_left--;
		stall_tick++;
		case (ready_mode)
			READY_ALWAYS: m_tready = 1'b1;
			READY_RANDOM: m_tready = ($urandom_range(0, 9) < 6);
			READY_PERIODIC: m_tready = (stall_tick % 7) < 4;
			default: m_tready = (stall_tick % 16) >= 11;
		endcase
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_pixel(m_tdata, m_tlast);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_selective_contour_erosion_3x3_top failed");
			$finish;
		end
	end

	function automatic void make_pixel(output logic [7:0] lab, output logic [7:0] gray);
		int pick, g;
		pick = $urandom_range(0, 19);
		if (pick < 7)
			lab = 8'd0;
		else if (pick < 16)
			lab = cur_any ? fg_label : cur_level;
		else
			lab = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			gray = 8'($urandom_range(0, 255));
		end else begin
			g = gray_base + int'($urandom_range(0, 48)) - 24;
			gray = (g < 0) ? 8'd0 : ((g > 255) ? 8'd255 : g[7:0]);
		end
	endfunction

	task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value;
		@(posedge clk);
		board.write_reg(idx, value);
	endtask

	task automatic apply_settings(input logic any, input logic [7:0] level,
			input logic signed [15:0] th, input logic [10:0] w, input logic [11:0] h);
		write_config(CFG_MATCH_ANY, {15'd0, any});
		write_config(CFG_LEVEL, {8'd0, level});
		write_config(CFG_THRESHOLD, th);
		write_config(CFG_WIDTH, {5'd0, w});
		write_config(CFG_HEIGHT, {4'd0, h});
		@(negedge clk);
		cfg_we = 1'b0;
		cur_any = any;
		cur_level = level;
	endtask

	task automatic push_pixel(input logic [7:0] lab, input logic [7:0] gray);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {gray, lab};
		do @(posedge clk); while (s_tready !== 1'b1);
		board.take_pixel(lab, gray);
		pixels_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
	endtask

	// words in the first two rows or columns give no result, so settle a little after the last one
	task automatic drain();
		pause_sender(1);
		while (board.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic stream_pixels(input int count);
		int burst_left;
		logic [7:0] lab, gray;
		burst_left = 0;
		repeat (count) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if (gaps_on)
					pause_sender($urandom_range(1, 6));
			end
			burst_left--;
			if ($urandom_range(0, 299) == 0)
				drain();
			make_pixel(lab, gray);
			push_pixel(lab, gray);
		end
	endtask

	// lead words first (may stop mid-frame), then whole frames
	task automatic run_phase(input logic any, input logic [7:0] level,
			input logic signed [15:0] th, input logic [10:0] w, input logic [11:0] h,
			input int lead, input int frames);
		apply_settings(any, level, th, w, h);
		gaps_on = ($urandom_range(0, 3) != 0);
		fg_label = 8'($urandom_range(1, 255));
		gray_base = $urandom_range(0, 255);
		stream_pixels(lead);
		repeat (frames)
			stream_pixels(board.pixels_to_frame_end());
		drain();
	endtask

	initial begin
		logic any_r;
		logic [7:0] lvl_r;
		logic signed [15:0] th_r;
		logic [10:0] w_r;
		logic [11:0] h_r;
		int pick, random_start;

		board = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// hand-built 5x5 frame: forced border labels, gray extremes, mixed contours
		apply_settings(1'b1, 8'd255, 16'sd300, 11'd5, 12'd5);
		for (int i = 0; i < 25; i++)
			push_pixel(dir_lab[i], dir_gray[i]);
		drain();

		// level mode with level 0: background centers count as component
		run_phase(1'b0, 8'd0, 16'sd200, 11'd4, 12'd4, 0, 2);
		// undersized geometry clamps to 3x3, threshold at its top
		run_phase(1'b0, 8'd255, 16'h7FFF, 11'd0, 12'd1, 0, 4);
		// oversized width wraps at the line length, threshold at its bottom;
		// the frame is closed on a narrow width once the second row has begun
		run_phase(1'b1, 8'd0, 16'h8000, 11'd2047, 12'd3, 1030, 0);
		run_phase(1'b1, 8'd0, 16'h8000, 11'd8, 12'd3, 0, 1);
		// tallest frame cut short by lowering the height mid-frame
		run_phase(1'b1, 8'd255, 16'sd400, 11'd3, 12'd4095, 120, 0);
		run_phase(1'b1, 8'd255, 16'sd400, 11'd3, 12'd2, 0, 1);
		// width shrunk mid-row: the current column wraps at once
		run_phase(1'b0, 8'd77, 16'sd250, 11'd20, 12'd10, 93, 0);
		run_phase(1'b0, 8'd77, 16'sd250, 11'd8, 12'd10, 0, 1);

		random_start = pixels_sent;
		while (pixels_sent - random_start < RANDOM_PIXELS) begin
			any_r = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 3);
			lvl_r = (pick == 0) ? 8'd0 : ((pick == 1) ? 8'd255 : 8'($urandom_range(1, 254)));
			pick = $urandom_range(0, 9);
			if (pick < 7)
				th_r = 16'($urandom_range(5, 700));
			else if (pick < 9)
				th_r = 16'($urandom_range(0, 65535));
			else
				th_r = 16'(-int'($urandom_range(0, 40)));
			pick = $urandom_range(0, 9);
			if (pick < 8)
				w_r = 11'($urandom_range(3, 14));
			else if (pick < 9)
				w_r = 11'($urandom_range(0, 2));
			else
				w_r = 11'($urandom_range(15, 64));
			h_r = ($urandom_range(0, 6) == 0) ? 12'($urandom_range(0, 2)) :
				12'($urandom_range(3, 8));
			run_phase(any_r, lvl_r, th_r, w_r, h_r, 0, $urandom_range(1, 3));
		end

		drain();
		if (board.fail_count == 0)
			$display("tb_selective_contour_erosion_3x3_top passed");
		else
			$display("tb_selective_contour_erosion_3x3_top failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sce_pkg.sv
src/sce_eval.sv
src/selective_contour_erosion_3x3_top.sv
tb/tb_selective_contour_erosion_3x3_top.sv
